// ===== hdl/nis_pkg.sv =====
package nis_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned ThrW      = 31;
  localparam int unsigned IterW     = 8;
  localparam int unsigned RingDepth = 4;
  localparam int unsigned TagW      = $clog2(RingDepth);

  localparam logic [IterW-1:0] MaxIterations = 8'd64;

  localparam logic [DataW-1:0] GuessReset = 32'h0100_0000;
  localparam logic [ThrW-1:0]  ThrReset   = 31'd10737;
  localparam logic [DataW-1:0] OneQ30     = 32'h4000_0000;
  localparam logic [DataW-1:0] ThreeQ30   = 32'hC000_0000;
  localparam logic [DataW-1:0] Sat32      = 32'hFFFF_FFFF;

  // config register indexes
  localparam logic CfgGuess = 1'b0;
  localparam logic CfgThr   = 1'b1;

  // one item riding the ring
  typedef struct packed {
    logic             valid;
    logic             done;
    logic             conv;
    logic [TagW-1:0]  tag;
    logic [IterW-1:0] iter;
    logic [DataW-1:0] x;
    logic [DataW-1:0] g;    // guess, replaced by the root once done
    logic [DataW-1:0] aux;  // g2, then t, then d
  } slot_t;

  function automatic logic [DataW-1:0] sat_shr24(input logic [2*DataW-1:0] p);
    sat_shr24 = (p[63:56] != 8'd0) ? Sat32 : p[55:24];
  endfunction

endpackage

// ===== hdl/nis_square.sv =====
module nis_square (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nis_pkg::slot_t s_i,
  output nis_pkg::slot_t s_o
);

  nis_pkg::slot_t s0_q, s0_d, s1_q, s1_d;
  logic [63:0] p0, p1;

  // g2 = g*g >> 24
  always_comb begin
    p0 = {32'd0, s_i.g} * {32'd0, s_i.g};
    s0_d = s_i;
    if (s_i.valid && !s_i.done) begin
      s0_d.aux = nis_pkg::sat_shr24(p0);
    end
  end

  // t = g2*x >> 24
  always_comb begin
    p1 = {32'd0, s0_q.aux} * {32'd0, s0_q.x};
    s1_d = s0_q;
    if (s0_q.valid && !s0_q.done) begin
      s1_d.aux = nis_pkg::sat_shr24(p1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
      s1_q <= '0;
    end else begin
      s0_q <= s0_d;
      s1_q <= s1_d;
    end
  end

  assign s_o = s1_q;

endmodule

// ===== hdl/nis_update.sv =====
module nis_update (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [nis_pkg::ThrW-1:0]  thr_i,
  input  nis_pkg::slot_t            s_i,
  output nis_pkg::slot_t            s_o
);

  nis_pkg::slot_t s2_q, s2_d, s3_q, s3_d;
  logic [nis_pkg::DataW-1:0] err;
  logic                      fin_q, fin_d;
  logic [63:0]               prod;

  // error test and update factor
  always_comb begin
    s2_d  = s_i;
    fin_d = 1'b0;
    err   = (s_i.aux >= nis_pkg::OneQ30) ? s_i.aux - nis_pkg::OneQ30
                                         : nis_pkg::OneQ30 - s_i.aux;
    if (s_i.valid && !s_i.done) begin
      if (err <= {1'b0, thr_i}) begin
        s2_d.done = 1'b1;
        s2_d.conv = 1'b1;
        fin_d     = 1'b1;
      end else if (s_i.iter == nis_pkg::MaxIterations) begin
        s2_d.done = 1'b1;
        s2_d.conv = 1'b0;
        fin_d     = 1'b1;
      end
      s2_d.aux = (s_i.aux >= nis_pkg::ThreeQ30) ? '0 : nis_pkg::ThreeQ30 - s_i.aux;
    end
  end

  // one shared multiply: new guess, or root on the lap that finishes
  always_comb begin
    prod = {32'd0, s2_q.g} * {32'd0, (fin_q ? s2_q.x : s2_q.aux)};
    s3_d = s2_q;
    if (s2_q.valid) begin
      if (fin_q) begin
        s3_d.g = (prod[63:62] != 2'd0) ? nis_pkg::Sat32 : prod[61:30];
      end else if (!s2_q.done) begin
        s3_d.g    = prod[63] ? nis_pkg::Sat32 : prod[62:31];
        s3_d.iter = s2_q.iter + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q  <= '0;
      s3_q  <= '0;
      fin_q <= 1'b0;
    end else begin
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      fin_q <= fin_d;
    end
  end

  assign s_o = s3_q;

endmodule

// ===== hdl/newton_inverse_sqrt_root.sv =====
// Newton inverse square root, fixed point.
// Input channel: x_value_i (Q2.30) with in_valid_i / in_ready_o; a transfer
// happens when both are high. Output channel: root_o (Q8.24), converged_o,
// iterations_used_o with out_valid_o / out_ready_i, results in input order.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 initial guess,
// 1 error threshold) in the same cycle; write only while idle.
// Items circulate in a 4-stage ring (square, multiply by x, error test,
// update multiply); one Newton lap is one pass round the ring, and up to
// 4 items share the ring, so a new item can enter before older ones have
// finished. A finished item may also wait for older items to leave.
// A new item enters only when the slot returning to the ring head is free.
// If the receiver stalls, finished items keep circulating without change
// and input is refused once the ring fills; nothing is dropped.
// Reset empties the ring and output register and restores the defaults
// (guess 1.0, threshold 10737).
module newton_inverse_sqrt_root (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] x_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] root_o,
  output logic        converged_o,
  output logic [7:0]  iterations_used_o
);

  logic [nis_pkg::DataW-1:0] guess_q;
  logic [nis_pkg::ThrW-1:0]  thr_q;
  logic [nis_pkg::TagW-1:0]  head_q, tail_q;
  nis_pkg::slot_t            ring_in, mid, back;
  logic                      retire, keep;
  logic                      out_valid_q;
  logic [31:0]               root_q;
  logic                      conv_q;
  logic [7:0]                iter_q;

  assign retire = back.valid && back.done && (back.tag == head_q) &&
                  (!out_valid_q || out_ready_i);
  assign keep   = back.valid && !retire;
  assign in_ready_o = !keep;

  always_comb begin
    if (keep) begin
      ring_in = back;
    end else begin
      ring_in       = '0;
      ring_in.valid = in_valid_i;
      ring_in.tag   = tail_q;
      ring_in.x     = x_value_i;
      ring_in.g     = guess_q;
    end
  end

  nis_square u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s_i    (ring_in),
    .s_o    (mid)
  );

  nis_update u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .thr_i  (thr_q),
    .s_i    (mid),
    .s_o    (back)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guess_q     <= nis_pkg::GuessReset;
      thr_q       <= nis_pkg::ThrReset;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == nis_pkg::CfgGuess) begin
        guess_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == nis_pkg::CfgThr) begin
        thr_q <= cfg_data_i[30:0];
      end
      if (in_valid_i && in_ready_o) begin
        tail_q <= tail_q + 1'b1;
      end
      if (retire) begin
        head_q      <= head_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      root_q <= back.g;
      conv_q <= back.conv;
      iter_q <= back.iter;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign root_o            = root_q;
  assign converged_o       = conv_q;
  assign iterations_used_o = iter_q;

endmodule

// ===== hdl/nis_checker.sv =====
module nis_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [31:0] root_o,
  input logic       converged_o,
  input logic [7:0] iterations_used_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_o))
    else $error("output changed under stall");

  a_iter_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> iterations_used_o <= nis_pkg::MaxIterations)
    else $error("iteration count beyond limit");

  a_noconv_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !converged_o |-> iterations_used_o == nis_pkg::MaxIterations)
    else $error("unconverged result before limit");

endmodule

bind newton_inverse_sqrt_root nis_checker u_nis_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .root_o            (root_o),
  .converged_o       (converged_o),
  .iterations_used_o (iterations_used_o)
);
